// ----- rtl/ttdc_pkg.sv -----
// Shared constants, codes and control/status types for the text terminal display controller.
`timescale 1ns / 1ps

package ttdc_pkg;

	localparam int COLUMNS = 80;
	localparam int LINES   = 25;
	localparam int CELLS   = COLUMNS * LINES;

	localparam int COL_W  = $clog2(COLUMNS);
	localparam int ROW_W  = $clog2(LINES);
	localparam int MEM_AW = $clog2(CELLS);
	localparam int CNT_W  = $clog2(CELLS + 1);

	localparam logic [COL_W-1:0] COL_LAST = COL_W'(COLUMNS - 1);
	localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(LINES - 1);

	// Access kinds.
	localparam logic REQ_READ  = 1'b0;
	localparam logic REQ_WRITE = 1'b1;

	// Bus ports.
	localparam logic [7:0] PORT_DATA   = 8'd0;
	localparam logic [7:0] PORT_COL    = 8'd1;
	localparam logic [7:0] PORT_ROW    = 8'd2;
	localparam logic [7:0] PORT_STATUS = 8'd3;
	localparam logic [7:0] PORT_IDENT  = 8'd15;

	// Cursor control codes on the data port.
	localparam logic [7:0] CH_BS    = 8'd8;
	localparam logic [7:0] CH_CR    = 8'd13;
	localparam logic [7:0] CH_LEFT  = 8'd17;
	localparam logic [7:0] CH_RIGHT = 8'd18;
	localparam logic [7:0] CH_UP    = 8'd19;
	localparam logic [7:0] CH_DOWN  = 8'd20;

	// Status byte bits.
	localparam int ST_ADV_X  = 0;
	localparam int ST_WRAP_X = 1;
	localparam int ST_ADV_Y  = 2;
	localparam int ST_SCROLL = 3;
	localparam int ST_CMD    = 7;

	// Status port commands.
	localparam logic [6:0] CMD_CLEAR     = 7'd0;
	localparam logic [6:0] CMD_SCROLL    = 7'd1;
	localparam logic [6:0] CMD_TIMER_ON  = 7'd2;
	localparam logic [6:0] CMD_TIMER_OFF = 7'd3;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_IDENT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FAMILY_IDENT = 1'd1;

	typedef struct packed {
		logic accept;
		logic commit;
		logic sweep_init;
		logic sweep_run;
	} ttdc_ctrl_t;

	typedef struct packed {
		logic out_free;
		logic go_sweep;
		logic sweep_done;
	} ttdc_stat_t;

endpackage

// ----- rtl/ttdc_ctrl.sv -----
// Controller state machine: sequences accept, execute and memory sweeps.
`timescale 1ns / 1ps

module ttdc_ctrl
	import ttdc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_ready,
	input  ttdc_stat_t stat,
	output ttdc_ctrl_t ctrl
);

	typedef enum logic [1:0] {
		S_SWEEP,
		S_IDLE,
		S_EXEC
	} state_t;

	state_t state_q;

	assign req_ready       = (state_q == S_IDLE);
	assign ctrl.accept     = (state_q == S_IDLE) && req_valid;
	assign ctrl.commit     = (state_q == S_EXEC) && stat.out_free;
	assign ctrl.sweep_init = ctrl.commit && stat.go_sweep;
	assign ctrl.sweep_run  = (state_q == S_SWEEP);

	// Reset starts in the sweep state so the character memory is cleared first.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_SWEEP;
		end else begin
			case (state_q)
				S_SWEEP: begin
					if (stat.sweep_done) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (req_valid) state_q <= S_EXEC;
				end
				S_EXEC: begin
					if (stat.out_free) state_q <= stat.go_sweep ? S_SWEEP : S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	property p_no_accept_while_sweeping;
		@(posedge clk) disable iff (!arst_n)
		(state_q == S_SWEEP) |-> !ctrl.accept && !ctrl.commit;
	endproperty
	a_no_accept_while_sweeping: assert property (p_no_accept_while_sweeping)
		else $error("transaction accepted or committed during a memory sweep");

endmodule

// ----- rtl/ttdc_datapath.sv -----
// Datapath: character memory, cursor, status, identifiers, sweep engine and result register.
`timescale 1ns / 1ps

module ttdc_datapath
	import ttdc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  ttdc_ctrl_t           ctrl,
	output ttdc_stat_t           stat,
	input  logic                 req_type,
	input  logic [7:0]           port_addr,
	input  logic [7:0]           write_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]           cfg_data,
	output logic                 rsp_valid,
	input  logic                 rsp_ready,
	output logic [7:0]           read_data,
	output logic                 timer_enable
);

	logic [7:0] char_mem [CELLS];

	// Latched transaction.
	logic       type_q;
	logic [7:0] port_q;
	logic [7:0] wdata_q;

	// Architectural state.
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [6:0]       status_q;
	logic             toggle_q;
	logic             timer_q;
	logic [7:0]       screen_ident_q;
	logic [7:0]       family_ident_q;

	// Sweep engine.
	logic [CNT_W-1:0]  idx_q;
	logic              scroll_q;
	logic              wv_s1;
	logic [MEM_AW-1:0] widx_s1;
	logic [CNT_W:0]    src_sum;
	logic [MEM_AW-1:0] src_addr;
	logic [7:0]        sweep_wdata;

	logic [7:0]        rdata_q;
	logic [MEM_AW-1:0] cell_idx;
	logic [MEM_AW-1:0] rd_addr;

	logic             rsp_valid_q;
	logic [7:0]       read_data_q;
	logic             timer_out_q;

	// Next-state values for the committing transaction.
	logic [COL_W-1:0] col_d;
	logic [ROW_W-1:0] row_d;
	logic [6:0]       status_d;
	logic             toggle_d;
	logic             timer_d;
	logic [7:0]       rd_d;
	logic             chr_we;
	logic             go_scroll;
	logic             go_clear;

	assign cfg_ready = 1'b1;

	assign cell_idx = MEM_AW'(row_q) * MEM_AW'(COLUMNS) + MEM_AW'(col_q);
	assign src_sum  = (CNT_W + 1)'(idx_q) + (CNT_W + 1)'(COLUMNS);
	assign src_addr = (src_sum < (CNT_W + 1)'(CELLS)) ? src_sum[MEM_AW-1:0] : '0;
	assign rd_addr  = ctrl.sweep_run ? src_addr : cell_idx;

	// A scroll copies each cell from one line below; the last line and a clear get zeros.
	assign sweep_wdata = (scroll_q && (widx_s1 < MEM_AW'(CELLS - COLUMNS))) ? rdata_q : 8'h00;

	always_ff @(posedge clk) begin
		rdata_q <= char_mem[rd_addr];
		if (wv_s1) begin
			char_mem[widx_s1] <= sweep_wdata;
		end else if (ctrl.commit && chr_we) begin
			char_mem[cell_idx] <= wdata_q;
		end
	end

	always_comb begin
		col_d     = col_q;
		row_d     = row_q;
		status_d  = status_q;
		toggle_d  = toggle_q;
		timer_d   = timer_q;
		rd_d      = 8'h00;
		chr_we    = 1'b0;
		go_scroll = 1'b0;
		go_clear  = 1'b0;
		if (type_q == REQ_WRITE) begin
			case (port_q)
				PORT_DATA: begin
					case (wdata_q) inside
						CH_BS, CH_LEFT: begin
							if (col_q != '0) col_d = col_q - 1'b1;
						end
						CH_CR: begin
							col_d = '0;
							if (row_q < ROW_LAST) row_d = row_q + 1'b1;
							else go_scroll = 1'b1;
						end
						CH_RIGHT: begin
							if (col_q < COL_LAST) col_d = col_q + 1'b1;
						end
						CH_UP: begin
							if (row_q != '0) row_d = row_q - 1'b1;
						end
						CH_DOWN: begin
							if (row_q < ROW_LAST) row_d = row_q + 1'b1;
						end
						default: begin
							chr_we = 1'b1;
							if (status_q[ST_ADV_X]) begin
								if (col_q >= COL_LAST) begin
									if (status_q[ST_WRAP_X]) col_d = '0;
									if (status_q[ST_ADV_Y]) begin
										if (row_q >= ROW_LAST) go_scroll = status_q[ST_SCROLL];
										else row_d = row_q + 1'b1;
									end
								end else begin
									col_d = col_q + 1'b1;
								end
							end
						end
					endcase
				end
				PORT_COL: begin
					col_d = (wdata_q < 8'(COLUMNS)) ? COL_W'(wdata_q) : COL_LAST;
				end
				PORT_ROW: begin
					row_d = (wdata_q < 8'(LINES)) ? ROW_W'(wdata_q) : ROW_LAST;
				end
				PORT_STATUS: begin
					if (!wdata_q[ST_CMD]) begin
						status_d = wdata_q[6:0];
					end else begin
						case (wdata_q[6:0])
							CMD_CLEAR: begin
								go_clear = 1'b1;
								col_d    = '0;
								row_d    = '0;
							end
							CMD_SCROLL: begin
								go_scroll = 1'b1;
								if (row_q != '0) row_d = row_q - 1'b1;
							end
							CMD_TIMER_ON:  timer_d = 1'b1;
							CMD_TIMER_OFF: timer_d = 1'b0;
							default: ;
						endcase
					end
				end
				default: ;
			endcase
		end else begin
			case (port_q)
				PORT_DATA:   rd_d = rdata_q;
				PORT_COL:    rd_d = 8'(col_q);
				PORT_ROW:    rd_d = 8'(row_q);
				PORT_STATUS: rd_d = 8'(status_q);
				PORT_IDENT: begin
					rd_d     = toggle_q ? screen_ident_q : family_ident_q;
					toggle_d = ~toggle_q;
				end
				default: ;
			endcase
		end
	end

	assign stat.out_free   = !rsp_valid_q || rsp_ready;
	assign stat.go_sweep   = go_scroll || go_clear;
	assign stat.sweep_done = (idx_q == CNT_W'(CELLS)) && !wv_s1;

	always_ff @(posedge clk) begin
		if (ctrl.accept) begin
			type_q  <= req_type;
			port_q  <= port_addr;
			wdata_q <= write_data;
		end
		if (ctrl.commit) begin
			read_data_q <= rd_d;
			timer_out_q <= timer_d;
		end
		widx_s1 <= idx_q[MEM_AW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q          <= '0;
			row_q          <= '0;
			status_q       <= '0;
			toggle_q       <= 1'b0;
			timer_q        <= 1'b0;
			screen_ident_q <= '0;
			family_ident_q <= '0;
			idx_q          <= '0;
			scroll_q       <= 1'b0;
			wv_s1          <= 1'b0;
			rsp_valid_q    <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					REG_SCREEN_IDENT: screen_ident_q <= cfg_data;
					REG_FAMILY_IDENT: family_ident_q <= cfg_data;
					default: ;
				endcase
			end
			if (ctrl.commit) begin
				col_q    <= col_d;
				row_q    <= row_d;
				status_q <= status_d;
				toggle_q <= toggle_d;
				timer_q  <= timer_d;
			end
			if (ctrl.sweep_init) begin
				idx_q    <= '0;
				scroll_q <= go_scroll;
				wv_s1    <= 1'b0;
			end else if (ctrl.sweep_run && (idx_q != CNT_W'(CELLS))) begin
				idx_q <= idx_q + 1'b1;
				wv_s1 <= 1'b1;
			end else begin
				wv_s1 <= 1'b0;
			end
			if (ctrl.commit) rsp_valid_q <= 1'b1;
			else if (rsp_ready) rsp_valid_q <= 1'b0;
		end
	end

	assign rsp_valid    = rsp_valid_q;
	assign read_data    = read_data_q;
	assign timer_enable = timer_out_q;

	property p_cursor_in_range;
		@(posedge clk) disable iff (!arst_n)
		(col_q <= COL_LAST) && (row_q <= ROW_LAST);
	endproperty
	a_cursor_in_range: assert property (p_cursor_in_range)
		else $error("cursor left the screen");

	property p_commit_needs_slot;
		@(posedge clk) disable iff (!arst_n)
		ctrl.commit |-> (!rsp_valid_q || rsp_ready);
	endproperty
	a_commit_needs_slot: assert property (p_commit_needs_slot)
		else $error("result register overwritten before its transaction");

	property p_sweep_write_exclusive;
		@(posedge clk) disable iff (!arst_n)
		wv_s1 |-> !ctrl.commit && !ctrl.accept;
	endproperty
	a_sweep_write_exclusive: assert property (p_sweep_write_exclusive)
		else $error("sweep write overlaps a transaction");

	property p_sweep_count_bound;
		@(posedge clk) disable iff (!arst_n)
		idx_q <= CNT_W'(CELLS);
	endproperty
	a_sweep_count_bound: assert property (p_sweep_count_bound)
		else $error("sweep index ran past the memory");

endmodule

// ----- rtl/text_terminal_display_controller_top.sv -----
// Result: the request is latched when it is accepted, and the result is registered when the execute
// step commits it, once the result register is free to take it.
// Requests: a new access is accepted only in the idle state, after the previous one has committed.
// A clear or scroll then walks the character memory, and no request is accepted until it is done.
// Reset: asynchronous, active low; afterwards a clearing pass zeros the character memory before
// the first request is accepted (configuration is taken always).
`timescale 1ns / 1ps

module text_terminal_display_controller_top
	import ttdc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_ready,
	input  logic                 req_type,
	input  logic [7:0]           port_addr,
	input  logic [7:0]           write_data,
	output logic                 rsp_valid,
	input  logic                 rsp_ready,
	output logic [7:0]           read_data,
	output logic                 timer_enable,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]           cfg_data
);

	ttdc_ctrl_t ctrl;
	ttdc_stat_t stat;

	ttdc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.stat      (stat),
		.ctrl      (ctrl)
	);

	ttdc_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctrl         (ctrl),
		.stat         (stat),
		.req_type     (req_type),
		.port_addr    (port_addr),
		.write_data   (write_data),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.rsp_valid    (rsp_valid),
		.rsp_ready    (rsp_ready),
		.read_data    (read_data),
		.timer_enable (timer_enable)
	);

endmodule
